FILE: rtl/crc_codeword_encoder_defines.svh
// Assertion macros shared by the CRC codeword encoder RTL.
`ifndef CRC_CODEWORD_ENCODER_DEFINES_SVH
`define CRC_CODEWORD_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define CRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/crc_enc_pkg.sv
// Package: types and constants of the CRC codeword encoder.
`default_nettype none
package crc_enc_pkg;

    localparam int MAX_DEGREE  = 32;
    localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
    localparam int CFG_POLY_W  = 32;
    localparam int CFG_DEG_W   = 6;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [MAX_DEGREE-1:0] rem_t;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_POLY   = 1'b0,
        REG_DEGREE = 1'b1
    } reg_idx_t;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic             msg_bit;
        logic             last;
        logic [DEG_W-1:0] degree;
        rem_t             rem;
    } crc_item_t;

endpackage
`default_nettype wire

FILE: rtl/crc_codeword_encoder.sv
// Top level: CRC codeword encoder with APB configuration registers.
//
// Bit-serial CRC encoder. Each input item carries one message bit (MSB first) and
// is echoed as one code bit; after the item marked tlast the degree check bits
// follow, MSB first, with tuser high, and the final bit of the codeword has tlast
// high (with degree zero that is the message bit itself). A new bit is taken every
// cycle: the remainder LFSR does one XOR level per bit. Output runs at one item per
// cycle while m_tready holds high; a four-entry queue keeps taking input while check
// bits drain, and the input stalls only when it fills. From input accept to output
// valid an item passes through the queue entry register and the output register.
// Registers: 0x0 generator_poly (bit i = coefficient of x^i below the leading one,
// reset 0x7), 0x4 generator_degree (6 bits, saturates at 32, reset 3).
`default_nettype none
module crc_codeword_encoder
    import crc_enc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [0] message_bit, [7:1] zero
    input  wire logic                  s_tlast,   // last_message_bit
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [0] code_bit, [7:1] zero
    output logic                       m_tuser,   // is_check_bit
    output logic                       m_tlast,   // end_of_codeword
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [CFG_POLY_W-1:0] poly_reg;
    logic [CFG_POLY_W-1:0] poly_next;
    logic [CFG_DEG_W-1:0]  degree_reg;
    logic [CFG_DEG_W-1:0]  degree_next;
    reg_idx_t              reg_idx;
    logic                  wr_en;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_valid;
    crc_item_t             push_item;
    crc_item_t             pop_item;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        poly_next   = poly_reg;
        degree_next = degree_reg;
        prdata      = '0;
        unique case (reg_idx)
            REG_POLY: begin
                prdata = APB_DATA_W'(poly_reg);
                if (wr_en) begin
                    poly_next = pwdata[CFG_POLY_W-1:0];
                end
            end
            REG_DEGREE: begin
                prdata = APB_DATA_W'(degree_reg);
                if (wr_en) begin
                    degree_next = pwdata[CFG_DEG_W-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg   <= CFG_POLY_W'(7);
            degree_reg <= CFG_DEG_W'(3);
        end else begin
            poly_reg   <= poly_next;
            degree_reg <= degree_next;
        end
    end

    crc_enc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_poly   (poly_reg),
        .cfg_degree (degree_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    crc_enc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .not_empty (q_valid),
        .full      (q_full)
    );

    crc_enc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

FILE: rtl/crc_enc_front.sv
// Front: takes message bits, runs the remainder LFSR and queues items.
`default_nettype none
`include "crc_codeword_encoder_defines.svh"
module crc_enc_front
    import crc_enc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [0] message_bit, [7:1] zero
    input  wire logic                  s_tlast,   // last_message_bit
    input  wire logic [CFG_POLY_W-1:0] cfg_poly,
    input  wire logic [CFG_DEG_W-1:0]  cfg_degree,
    input  wire logic                  q_full,
    output logic                       q_push,
    output crc_item_t                  q_item
);

    rem_t             rem_reg;
    rem_t             rem_next;
    rem_t             mask;
    rem_t             rem_m;
    rem_t             rem_shr;
    rem_t             rem_new;
    rem_t             poly_ext;
    logic [DEG_W-1:0] deg;
    logic             fb;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    always_comb begin
        // degrees above the maximum saturate
        if ({2'b00, cfg_degree} > 8'(MAX_DEGREE)) begin
            deg = DEG_W'(MAX_DEGREE);
        end else begin
            deg = DEG_W'(cfg_degree);
        end
        mask     = ~({MAX_DEGREE{1'b1}} << deg);
        poly_ext = MAX_DEGREE'(cfg_poly);
        rem_m    = rem_reg & mask;
        rem_shr  = rem_m >> (deg - DEG_W'(1));
        fb       = (deg != '0) && (rem_shr[0] ^ s_tdata[0]);
        rem_new  = ((rem_m << 1) ^ (fb ? poly_ext : '0)) & mask;

        q_item.msg_bit = s_tdata[0];
        q_item.last    = s_tlast;
        q_item.degree  = deg;
        q_item.rem     = rem_new;

        rem_next = rem_reg;
        if (accept) begin
            rem_next = s_tlast ? '0 : rem_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    `CRC_ASSERT_NEXT(a_rem_clear_after_last, accept && s_tlast, rem_reg == '0,
        "remainder not cleared after last message bit")

endmodule
`default_nettype wire

FILE: rtl/crc_enc_queue.sv
// Queue: short register FIFO between the front and the back.
`default_nettype none
`include "crc_codeword_encoder_defines.svh"
module crc_enc_queue
    import crc_enc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire crc_item_t push_item,
    input  wire logic      pop,
    output crc_item_t      pop_item,
    output logic           not_empty,
    output logic           full
);

    crc_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `CRC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH),
        "queue count above depth")

endmodule
`default_nettype wire

FILE: rtl/crc_enc_back.sv
// Back: emits the message bit, then shifts out the check bits.
`default_nettype none
`include "crc_codeword_encoder_defines.svh"
module crc_enc_back
    import crc_enc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire crc_item_t   q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] code_bit, [7:1] zero
    output logic             m_tuser,   // is_check_bit
    output logic             m_tlast    // end_of_codeword
);

    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic             code_reg;
    logic             code_next;
    logic             check_reg;
    logic             check_next;
    logic             end_reg;
    logic             end_next;
    logic [DEG_W-1:0] cnt_reg;
    logic [DEG_W-1:0] cnt_next;
    rem_t             sr_reg;
    rem_t             sr_next;
    logic             advance;

    assign advance  = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, code_reg};
    assign m_tuser  = check_reg;
    assign m_tlast  = end_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        code_next     = code_reg;
        check_next    = check_reg;
        end_next      = end_reg;
        cnt_next      = cnt_reg;
        sr_next       = sr_reg;
        q_pop         = 1'b0;
        if (advance) begin
            if (cnt_reg != '0) begin
                m_tvalid_next = 1'b1;
                code_next     = sr_reg[MAX_DEGREE-1];
                check_next    = 1'b1;
                end_next      = (cnt_reg == DEG_W'(1));
                sr_next       = sr_reg << 1;
                cnt_next      = cnt_reg - DEG_W'(1);
            end else if (q_valid) begin
                q_pop         = 1'b1;
                m_tvalid_next = 1'b1;
                code_next     = q_item.msg_bit;
                check_next    = 1'b0;
                end_next      = q_item.last && (q_item.degree == '0);
                if (q_item.last) begin
                    cnt_next = q_item.degree;
                    // left-align so the remainder MSB is emitted first
                    sr_next  = q_item.rem << (DEG_W'(MAX_DEGREE) - q_item.degree);
                end
            end else begin
                m_tvalid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        check_reg <= check_next;
        end_reg   <= end_next;
        sr_reg    <= sr_next;
    end

    `CRC_ASSERT_NEXT(a_check_emitted, advance && (cnt_reg != '0),
        m_tvalid_reg && check_reg, "check bit not emitted while draining")
    `CRC_ASSERT_NEXT(a_final_check_flag, advance && (cnt_reg == DEG_W'(1)),
        end_reg && (cnt_reg == '0), "final check bit not flagged")
    `CRC_ASSERT_NOW(a_no_pop_while_draining, cnt_reg != '0, !q_pop,
        "item popped while check bits remain")

endmodule
`default_nettype wire
